/* design/mhmc_pkg.sv */
// Shared constants and types for the min-heap merge cost block.
`default_nettype none

package mhmc_pkg;

  localparam int unsigned CapacityDefault   = 1024;
  localparam int unsigned LengthBitsDefault = 16;

  // Fixed field widths.
  localparam int unsigned SegLenW = 16;
  localparam int unsigned CostW   = 48;

  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  // Operation broadcast to every cell of the sorted chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_MERGE  = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_e;

endpackage

`default_nettype wire

/* design/mhmc_cell.sv */
// One cell of the sorted priority chain: holds one entry, trades with its neighbors.
`default_nettype none

module mhmc_cell #(
  parameter int unsigned EntryW = 26
) (
  input  wire                  clk_i,
  input  wire mhmc_pkg::cell_op_e op_i,
  input  wire [EntryW-1:0]     key_i,
  input  wire                  occ_i,
  input  wire                  occ_next2_i,
  input  wire [EntryW-1:0]     prev_val_i,
  input  wire                  prev_le_i,
  input  wire [EntryW-1:0]     next1_val_i,
  input  wire [EntryW-1:0]     next2_val_i,
  output logic [EntryW-1:0]    val_o,
  output logic                 le_o
);
  import mhmc_pkg::*;

  logic [EntryW-1:0] val_q, val_d;
  logic [EntryW-1:0] cand;
  logic [EntryW-1:0] alt;
  logic              cand_occ;

  // On a merge the two smallest leave, so the chain moves up by two before
  // the new sum drops into its place.
  always_comb begin
    cand     = (op_i == CELL_MERGE) ? next2_val_i : val_q;
    cand_occ = (op_i == CELL_MERGE) ? occ_next2_i : occ_i;
    alt      = (op_i == CELL_MERGE) ? next1_val_i : prev_val_i;
    le_o     = cand_occ && (cand <= key_i);
  end

  always_comb begin
    unique case (op_i) inside
      CELL_INSERT, CELL_MERGE: begin
        if (le_o) begin
          val_d = cand;
        end else if (prev_le_i) begin
          val_d = key_i;
        end else begin
          val_d = alt;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* design/min_heap_merge_cost.sv */
// Minimum total merge cost of a set of segment lengths, top level.
//
// Input channel: in_valid_i / in_stall_o carry seg_length_i, has_length_i
// and last_item_i. Each transaction with has_length_i inserts the length
// into a sorted chain of CAPACITY cells; a length that arrives with the chain
// full is dropped. A transaction with last_item_i (after its own length, if
// any) starts merging.
// In each merge the two smallest entries leave the head of the chain, their
// sum is added to the cost and drops back into the chain in the same cycle.
// A set of n lengths takes n-1 merges, after which the result register is
// loaded; an empty or single-entry set loads cost 0 without merging.
// The input is stalled while merging runs, so a new set cannot start until
// the previous one has finished merging.
// Output channel: out_valid_o / out_stall_i carry total_cost_o and
// cost_saturated_o from a result register. A new set may load while a result
// waits; merging of that set holds at its end until the register is free.
// Reset empties the chain and clears the cost; no clearing pass is needed.
`default_nettype none

module min_heap_merge_cost #(
  parameter int unsigned CAPACITY    = mhmc_pkg::CapacityDefault,
  parameter int unsigned LENGTH_BITS = mhmc_pkg::LengthBitsDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [mhmc_pkg::SegLenW-1:0]  seg_length_i,
  input  wire                          has_length_i,
  input  wire                          last_item_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [mhmc_pkg::CostW-1:0]   total_cost_o,
  output logic                         cost_saturated_o
);
  import mhmc_pkg::*;

  localparam int unsigned EntryW = LENGTH_BITS + $clog2(CAPACITY);
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam logic [SegLenW-1:0] LenMask = (LENGTH_BITS >= SegLenW) ?
      {SegLenW{1'b1}} : SegLenW'((32'd1 << LENGTH_BITS) - 32'd1);

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CostW-1:0]   cost_q, cost_d;
  logic               sat_q, sat_d;
  logic               out_valid_q, out_valid_d;
  logic [CostW-1:0]   out_cost_q;
  logic               out_sat_q;

  cell_op_e           op;
  logic [EntryW-1:0]  key;
  logic [EntryW-1:0]  pair_sum;
  logic [CostW:0]     cost_sum;
  logic               in_xact;
  logic               full;
  logic               merge_go;
  logic               finish;

  logic [EntryW-1:0]  val [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic [CAPACITY-1:0] occ;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xact    = in_valid_i && (state_q == ST_IDLE);
  assign full       = (cnt_q == CntW'(CAPACITY));
  assign merge_go   = (state_q == ST_MERGE) && (cnt_q > CntW'(1));
  assign finish     = (state_q == ST_MERGE) && (cnt_q <= CntW'(1)) &&
                      (!out_valid_q || !out_stall_i);

  assign pair_sum = val[0] + val[1];
  assign cost_sum = {1'b0, cost_q} + (CostW + 1)'(pair_sum);

  always_comb begin
    op  = CELL_HOLD;
    key = EntryW'(seg_length_i & LenMask);
    if (in_xact && has_length_i && !full) begin
      op = CELL_INSERT;
    end else if (merge_go) begin
      op  = CELL_MERGE;
      key = pair_sum;
    end
  end

  // Occupancy follows from the fill count; the chain is kept sorted.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_occ
    assign occ[i] = (cnt_q > CntW'(i));
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EntryW-1:0] prev_val, next1_val, next2_val;
    logic              prev_le, occ_next2;

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_le  = 1'b1;
    end else begin : g_body
      assign prev_val = val[i-1];
      assign prev_le  = le[i-1];
    end

    if (i + 1 < CAPACITY) begin : g_n1
      assign next1_val = val[i+1];
    end else begin : g_n1_end
      assign next1_val = '0;
    end

    if (i + 2 < CAPACITY) begin : g_n2
      assign next2_val = val[i+2];
      assign occ_next2 = occ[i+2];
    end else begin : g_n2_end
      assign next2_val = '0;
      assign occ_next2 = 1'b0;
    end

    mhmc_cell #(
      .EntryW (EntryW)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .key_i       (key),
      .occ_i       (occ[i]),
      .occ_next2_i (occ_next2),
      .prev_val_i  (prev_val),
      .prev_le_i   (prev_le),
      .next1_val_i (next1_val),
      .next2_val_i (next2_val),
      .val_o       (val[i]),
      .le_o        (le[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cost_d      = cost_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xact) begin
          if (has_length_i && !full) begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (last_item_i) begin
            state_d = ST_MERGE;
          end
        end
      end
      ST_MERGE: begin
        if (merge_go) begin
          cnt_d = cnt_q - CntW'(1);
          if (cost_sum[CostW]) begin
            cost_d = CostMax;
            sat_d  = 1'b1;
          end else begin
            cost_d = cost_sum[CostW-1:0];
          end
        end else if (finish) begin
          out_valid_d = 1'b1;
          cnt_d       = '0;
          cost_d      = '0;
          sat_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cost_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cost_q      <= cost_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_cost_q <= cost_q;
      out_sat_q  <= sat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign total_cost_o     = out_cost_q;
  assign cost_saturated_o = out_sat_q;

endmodule

`default_nettype wire

/* design/mhmc_checker.sv */
// Port-level checks for min_heap_merge_cost, bound to the top level.
`default_nettype none

module mhmc_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_stall_o,
  input wire                          last_item_i,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire [mhmc_pkg::CostW-1:0]    total_cost_o,
  input wire                          cost_saturated_o
);
  import mhmc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Saturated totals are clamped to full scale.
  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cost_saturated_o |-> (total_cost_o == CostMax))
    else $error("saturated cost not clamped");

  // Closing a set always starts merging, which holds off the input.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_item_i |=> in_stall_o)
    else $error("input not stalled after end of set");

  // A new result only comes out of the merge phase.
  a_result_from_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without merge phase");

endmodule

bind min_heap_merge_cost mhmc_checker u_mhmc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .last_item_i      (last_item_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .total_cost_o     (total_cost_o),
  .cost_saturated_o (cost_saturated_o)
);

`default_nettype wire
